// ===== hdl/tlpd_pkg.sv =====
// Shared types and constants for the type-length packet deframer.
package tlpd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  // Header byte counter codes.
  localparam logic [2:0] HC_IDLE     = 3'd0;
  localparam logic [2:0] HC_LAST_LEN = 3'd4;
  localparam logic [2:0] HC_PAYLOAD  = 3'd5;

  typedef enum logic {
    ACT_BYTE       = 1'b0,
    ACT_DISCONNECT = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_DROP  = 2'd2
  } result_kind_t;

  typedef struct packed {
    action_t    action;
    logic [7:0] stream_byte;
  } in_item_t;

  typedef struct packed {
    result_kind_t result_kind;
    logic [7:0]   packet_type;
    logic [7:0]   payload_byte;
    logic         first_byte;
    logic         last_byte;
  } out_item_t;

endpackage

// ===== hdl/tlpd_stream_if.sv =====
// Valid/ready stream channel carrying one item per transfer.
interface tlpd_stream_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/tlpd_parser.sv =====
// Header/payload parser: state registers and per-byte result logic.
module tlpd_parser #(
  parameter int LENGTH_BITS = tlpd_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  tlpd_pkg::in_item_t item,
  output logic               res_valid,
  output tlpd_pkg::out_item_t res
);

  logic [2:0]             header_count;
  logic [2:0]             header_count_next;
  logic [7:0]             current_type;
  logic [7:0]             current_type_next;
  logic [LENGTH_BITS-1:0] length_remaining;
  logic [LENGTH_BITS-1:0] length_remaining_next;
  logic                   payload_started;
  logic                   payload_started_next;

  logic [1:0]             len_idx;
  logic [LENGTH_BITS-1:0] len_merged;
  logic                   last;

  assign len_idx    = 2'(header_count - 3'd1);
  // Little-endian length byte; bits beyond LENGTH_BITS fall off.
  assign len_merged = length_remaining
                    | (LENGTH_BITS'(item.stream_byte) << {len_idx, 3'b000});
  assign last       = (length_remaining <= LENGTH_BITS'(1));

  always_comb begin
    header_count_next     = header_count;
    current_type_next     = current_type;
    length_remaining_next = length_remaining;
    payload_started_next  = payload_started;
    res_valid             = 1'b0;
    res.result_kind       = tlpd_pkg::KIND_DATA;
    res.packet_type       = current_type;
    res.payload_byte      = 8'd0;
    res.first_byte        = 1'b0;
    res.last_byte         = 1'b0;
    if (accept) begin
      if (item.action == tlpd_pkg::ACT_DISCONNECT) begin
        res_valid             = (header_count != tlpd_pkg::HC_IDLE);
        res.result_kind       = tlpd_pkg::KIND_DROP;
        header_count_next     = tlpd_pkg::HC_IDLE;
        current_type_next     = 8'd0;
        length_remaining_next = '0;
        payload_started_next  = 1'b0;
      end else if (header_count == tlpd_pkg::HC_IDLE) begin
        current_type_next     = item.stream_byte;
        length_remaining_next = '0;
        payload_started_next  = 1'b0;
        header_count_next     = 3'd1;
      end else if (header_count < tlpd_pkg::HC_PAYLOAD) begin
        length_remaining_next = len_merged;
        payload_started_next  = 1'b0;
        if (header_count == tlpd_pkg::HC_LAST_LEN) begin
          if (len_merged == '0) begin
            res_valid         = 1'b1;
            res.result_kind   = tlpd_pkg::KIND_EMPTY;
            res.last_byte     = 1'b1;
            header_count_next = tlpd_pkg::HC_IDLE;
          end else begin
            header_count_next = tlpd_pkg::HC_PAYLOAD;
          end
        end else begin
          header_count_next = header_count + 3'd1;
        end
      end else begin
        // payload byte; spare counter codes land here too
        res_valid        = 1'b1;
        res.payload_byte = item.stream_byte;
        res.first_byte   = ~payload_started;
        res.last_byte    = last;
        if (last) begin
          length_remaining_next = '0;
          header_count_next     = tlpd_pkg::HC_IDLE;
          payload_started_next  = 1'b0;
        end else begin
          length_remaining_next = length_remaining - LENGTH_BITS'(1);
          payload_started_next  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count     <= tlpd_pkg::HC_IDLE;
      current_type     <= 8'd0;
      length_remaining <= '0;
      payload_started  <= 1'b0;
    end else begin
      header_count     <= header_count_next;
      current_type     <= current_type_next;
      length_remaining <= length_remaining_next;
      payload_started  <= payload_started_next;
    end
  end

endmodule

// ===== hdl/tlpd_out_reg.sv =====
// Result register driving the output channel.
module tlpd_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  tlpd_pkg::out_item_t item,
  output logic                space,
  tlpd_stream_if.source       result
);

  logic                valid;
  logic                valid_next;
  tlpd_pkg::out_item_t data;

  // Free now, or emptied by a transfer at this edge.
  assign space      = ~valid | result.ready;
  assign valid_next = load | (valid & ~result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= item;
    end
  end

  assign result.valid = valid;
  assign result.data  = data;

endmodule

// ===== hdl/type_length_packet_deframer.sv =====
// Top level of the type-length packet deframer.
//
//   channel  dir  payload                                             per transfer
//   stream   in   action, stream_byte                                 one byte or disconnect
//   result   out  result_kind, packet_type, payload_byte, first/last  zero or one per input
//
// One input transfer per clock is sustained while the result register has room;
// a result appears on the output register the cycle after the input that causes it.
// Throughput is set by the single result register: stream.ready drops
// only while that register is full and result.ready is low.
// Reset (rst, synchronous) returns the parser to waiting for a header
// and empties the result register.
module type_length_packet_deframer #(
  parameter int LENGTH_BITS = tlpd_pkg::LENGTH_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  tlpd_stream_if.sink   stream,
  tlpd_stream_if.source result
);

  logic                accept;
  logic                space;
  logic                res_valid;
  tlpd_pkg::out_item_t res;

  // A new byte is taken whenever the result register can hold what it
  // produces; inputs that produce nothing are taken under the same rule.
  assign stream.ready = space;
  assign accept       = stream.valid & space;

  tlpd_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (stream.data),
    .res_valid (res_valid),
    .res       (res)
  );

  // res_valid is only raised on an accepted transfer.
  tlpd_out_reg u_out_reg (
    .clk    (clk),
    .rst    (rst),
    .load   (res_valid),
    .item   (res),
    .space  (space),
    .result (result)
  );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the type-length packet deframer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpd_pkg::*;

  // Deframer length width under test; the predictor keeps the same width.
  localparam int LEN_BITS = LENGTH_BITS_DEF;
  // Cycles with no transfer on either channel before the run is declared hung.
  // The longest legal quiet stretch is the forced receiver hold-off below.
  localparam int unsigned HANG_LIMIT = 4000;
  // Length of the forced receiver hold-off, and the input count that starts it.
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned HOLD_AFTER = 300;
  // Extra drain time after the result register, with generous margin.
  localparam int unsigned DRAIN_CYCLES = 20;

  logic clk;
  logic rst;

  tlpd_stream_if #(.item_t(in_item_t))  stream_ch ();
  tlpd_stream_if #(.item_t(out_item_t)) result_ch ();

  type_length_packet_deframer #(.LENGTH_BITS(LEN_BITS)) dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .result (result_ch)
  );

  // 20 ns period.
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Stimulus waiting to be transferred, and results predicted but not yet seen.
  in_item_t    pending_items[$];
  out_item_t   expected_results[$];

  int unsigned error_count = 0;
  int unsigned bytes_taken = 0;   // input transfers so far
  int unsigned send_idle_pct = 0; // chance the sender idles in a cycle
  int unsigned recv_stall_pct = 0; // chance the receiver stalls in a cycle
  logic        byte_taken;        // input transfer happened at the last rising edge

  // Predictor state: a shadow of the parser.
  logic [2:0]          hdr_count;
  logic [7:0]          cur_type;
  logic [LEN_BITS-1:0] len_left;
  logic                started;

  // ---------------------------------------------------------------------------
  // Predictor. Advances the shadow parser by one accepted input and queues
  // the result it causes, if any.
  // ---------------------------------------------------------------------------
  function automatic void deframe_predict(in_item_t it);
    out_item_t   res;
    int unsigned sh;
    logic        is_last;
    res = '0;
    res.packet_type = cur_type;
    if (it.action == ACT_DISCONNECT) begin
      // Only a packet in progress gets reported; idle disconnects are silent.
      if (hdr_count != HC_IDLE) begin
        res.result_kind = KIND_DROP;
        expected_results.insert(expected_results.size(), res);
      end
      hdr_count = HC_IDLE;
      cur_type  = '0;
      len_left  = '0;
      started   = 1'b0;
    end else if (hdr_count == HC_IDLE) begin
      // Type byte opens a new header.
      cur_type  = it.stream_byte;
      len_left  = '0;
      started   = 1'b0;
      hdr_count = 3'd1;
    end else if (hdr_count < HC_PAYLOAD) begin
      // Little-endian length byte; bits beyond LEN_BITS fall off.
      sh = 8 * (int'(hdr_count) - 1);
      len_left  = len_left | LEN_BITS'(64'(it.stream_byte) << sh);
      hdr_count = hdr_count + 3'd1;
      started   = 1'b0;
      if (hdr_count == HC_PAYLOAD && len_left == '0) begin
        // Zero-length packet closes right at the end of its header.
        res.result_kind = KIND_EMPTY;
        res.last_byte   = 1'b1;
        expected_results.insert(expected_results.size(), res);
        hdr_count = HC_IDLE;
      end
    end else begin
      // Payload byte.
      is_last = (len_left <= 1);
      res.result_kind  = KIND_DATA;
      res.payload_byte = it.stream_byte;
      res.first_byte   = !started;
      res.last_byte    = is_last;
      expected_results.insert(expected_results.size(), res);
      if (is_last) begin
        len_left  = '0;
        hdr_count = HC_IDLE;
        started   = 1'b0;
      end else begin
        len_left = len_left - 1'b1;
        started  = 1'b1;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders.
  // ---------------------------------------------------------------------------
  task automatic push_byte(logic [7:0] v);
    in_item_t it;
    it.action      = ACT_BYTE;
    it.stream_byte = v;
    pending_items.insert(pending_items.size(), it);
  endtask

  // The byte lane is don't-care on a disconnect; randomize it anyway.
  task automatic push_disconnect();
    in_item_t it;
    it.action      = ACT_DISCONNECT;
    it.stream_byte = 8'($urandom);
    pending_items.insert(pending_items.size(), it);
  endtask

  // First 'count' bytes of a packet: header, then random payload.
  task automatic push_packet_bytes(logic [7:0] ptype, logic [31:0] len,
                                   int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i == 0)
        push_byte(ptype);
      else if (i < 5)
        push_byte(len[8*(i-1) +: 8]);
      else
        push_byte(8'($urandom));
    end
  endtask

  // One random session: mostly complete packets, some cut short by a
  // disconnect, some junk followed by a disconnect.
  task automatic push_random_session();
    int unsigned sel;
    int unsigned cut_max;
    logic [31:0] len;
    sel = $urandom_range(0, 99);
    if (sel < 72) begin
      sel = $urandom_range(0, 99);
      if (sel < 50)
        len = $urandom_range(0, 4);
      else if (sel < 90)
        len = $urandom_range(5, 24);
      else if (sel < 98)
        len = $urandom_range(25, 60);
      else
        len = $urandom_range(256, 300);  // second length byte nonzero
      push_packet_bytes(8'($urandom), len, 5 + len);
      if ($urandom_range(0, 9) == 0)
        push_disconnect();  // disconnect between packets
    end else if (sel < 90) begin
      // Truncated packet: full 32-bit random length or a short one.
      len = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(1, 30));
      if (len == 0)
        len = 1;
      cut_max = (len > 12) ? 16 : 4 + len;
      push_packet_bytes(8'($urandom), len, $urandom_range(1, cut_max));
      push_disconnect();
    end else begin
      // Junk bytes, possibly none, then a disconnect.
      repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
      push_disconnect();
    end
  endtask

  task automatic push_random_items(int unsigned target);
    while (pending_items.size() < target)
      push_random_session();
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: holds an offered item until it transfers, then offers the
  // next one or idles at the phase's rate.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      stream_ch.valid <= 1'b0;
    end else if (!stream_ch.valid || byte_taken) begin
      if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        stream_ch.valid <= 1'b1;
        stream_ch.data  <= pending_items[0];
      end else begin
        stream_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off early on so the
  // result register fills and the deframer has to stall its input.
  // ---------------------------------------------------------------------------
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      result_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && bytes_taken >= HOLD_AFTER) begin
      result_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each result transfer against the oldest prediction, then
  // predicts from the input transfer at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t got;
    out_item_t exp_res;
    if (rst) begin
      byte_taken <= 1'b0;
      hdr_count  = HC_IDLE;
      cur_type   = '0;
      len_left   = '0;
      started    = 1'b0;
    end else begin
      byte_taken <= stream_ch.valid && stream_ch.ready;
      if (result_ch.valid && result_ch.ready) begin
        got = result_ch.data;
        if (expected_results.size() == 0) begin
          $error("unexpected result: kind %0d type %0d data %0d",
                 got.result_kind, got.packet_type, got.payload_byte);
          error_count++;
        end else begin
          exp_res = expected_results[0];
          expected_results.delete(0);
          if (got.result_kind !== exp_res.result_kind) begin
            $error("result_kind: expected %0d, got %0d", exp_res.result_kind,
                   got.result_kind);
            error_count++;
          end
          if (got.packet_type !== exp_res.packet_type) begin
            $error("packet_type: expected %0d, got %0d", exp_res.packet_type,
                   got.packet_type);
            error_count++;
          end
          if (got.payload_byte !== exp_res.payload_byte) begin
            $error("payload_byte: expected %0d, got %0d", exp_res.payload_byte,
                   got.payload_byte);
            error_count++;
          end
          if (got.first_byte !== exp_res.first_byte) begin
            $error("first_byte: expected %0d, got %0d", exp_res.first_byte,
                   got.first_byte);
            error_count++;
          end
          if (got.last_byte !== exp_res.last_byte) begin
            $error("last_byte: expected %0d, got %0d", exp_res.last_byte,
                   got.last_byte);
            error_count++;
          end
        end
      end
      if (stream_ch.valid && stream_ch.ready) begin
        deframe_predict(stream_ch.data);
        pending_items.delete(0);
        bytes_taken++;
      end
    end
  end

  // Hang detector: counts cycles with no transfer on either channel.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (stream_ch.valid && stream_ch.ready) ||
        (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    stream_ch.valid = 1'b0;
    stream_ch.data  = '0;
    result_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, no idling on either side.
    push_disconnect();                              // disconnect while idle: silent
    push_packet_bytes(8'hFF, 32'd0, 5);             // empty packet
    push_packet_bytes(8'h00, 32'd1, 5);             // single byte: first and last
    push_byte(8'hFF);
    push_packet_bytes(8'h81, 32'h0000_0203, 3);     // drop in the middle of the header
    push_disconnect();
    push_packet_bytes(8'h7E, 32'hFFFF_FFFF, 5);     // maximum length, dropped mid-payload
    push_byte(8'h55);
    push_disconnect();

    // Random part, phase one: full rate; the long receiver hold-off lands here.
    push_random_items(500);
    wait_drained();

    // Sender idles often.
    send_idle_pct = 59;
    push_random_items(430);
    wait_drained();

    // Receiver stalls often.
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    push_random_items(430);
    wait_drained();

    // Both sides idle now and then.
    send_idle_pct  = 23;
    recv_stall_pct = 23;
    push_random_items(430);
    wait_drained();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/tlpd_pkg.sv
hdl/tlpd_stream_if.sv
hdl/tlpd_parser.sv
hdl/tlpd_out_reg.sv
hdl/type_length_packet_deframer.sv
tb/sv/tb.sv
